/* sv/sfwp_pkg.sv */
// Shared types and constants for the framed write stream parser.
// No dependencies; every other file of the block refers to this package.
package sfwp_pkg;

  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 16;
  localparam int PHASE_W = 3;
  localparam int RUN_W   = 3;

  localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'h55;
  localparam logic [ADDR_W-1:0] SYNC_ADDRESS = 16'h5555;
  localparam logic [ADDR_W-1:0] END_ADDRESS  = 16'hFFFE;
  localparam logic [ADDR_W-1:0] ADDR_STEP    = 16'd2;

  // One decoded write.
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic              frame_end;
  } write_t;

endpackage

/* sv/sfwp_parser.sv */
// Parse state machine of the framed write stream parser: updates the phase,
// sync run and record registers per byte. Depends on sfwp_pkg.
module sfwp_parser #(
  parameter int SYNC_RUN_LENGTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [sfwp_pkg::BYTE_W-1:0]  byte_in,
  output logic                         has_write,
  output sfwp_pkg::write_t             write_out
);

  localparam logic [sfwp_pkg::PHASE_W-1:0] PH_WAIT     = 3'd0;
  localparam logic [sfwp_pkg::PHASE_W-1:0] PH_ADDR_LO  = 3'd1;
  localparam logic [sfwp_pkg::PHASE_W-1:0] PH_ADDR_HI  = 3'd2;
  localparam logic [sfwp_pkg::PHASE_W-1:0] PH_COUNT_LO = 3'd3;
  localparam logic [sfwp_pkg::PHASE_W-1:0] PH_COUNT_HI = 3'd4;
  localparam logic [sfwp_pkg::PHASE_W-1:0] PH_DATA_LO  = 3'd5;
  localparam logic [sfwp_pkg::PHASE_W-1:0] PH_DATA_HI  = 3'd6;

  localparam logic [sfwp_pkg::RUN_W-1:0] RUN_LEN = sfwp_pkg::RUN_W'(SYNC_RUN_LENGTH);

  logic [sfwp_pkg::PHASE_W-1:0] phase, phase_next;
  logic [sfwp_pkg::RUN_W-1:0]   sync_run, sync_run_next, run_inc;
  logic [sfwp_pkg::ADDR_W-1:0]  cur_address, cur_address_next, hi_address;
  logic [15:0]                  bytes_left, bytes_left_next, bytes_dec;
  logic [sfwp_pkg::BYTE_W-1:0]  low_byte, low_byte_next;
  logic                         done;

  always_comb begin
    phase_next       = phase;
    cur_address_next = cur_address;
    bytes_left_next  = bytes_left;
    low_byte_next    = low_byte;
    bytes_dec        = bytes_left - 16'd1;
    hi_address       = {byte_in, cur_address[7:0]};
    done             = (bytes_dec == 16'd0);
    has_write        = 1'b0;
    write_out.address   = cur_address;
    write_out.data      = {byte_in, low_byte};
    write_out.frame_end = done && (cur_address == sfwp_pkg::END_ADDRESS);

    case (phase)
      PH_ADDR_LO: begin
        cur_address_next = {8'h00, byte_in};
        phase_next       = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        cur_address_next = hi_address;
        phase_next = (hi_address != sfwp_pkg::SYNC_ADDRESS) ? PH_COUNT_LO : PH_WAIT;
      end
      PH_COUNT_LO: begin
        bytes_left_next = {8'h00, byte_in};
        phase_next      = PH_COUNT_HI;
      end
      PH_COUNT_HI: begin
        bytes_left_next = {byte_in, bytes_left[7:0]};
        phase_next      = PH_DATA_LO;
      end
      PH_DATA_LO: begin
        low_byte_next   = byte_in;
        bytes_left_next = bytes_dec;
        phase_next      = PH_DATA_HI;
      end
      PH_DATA_HI: begin
        bytes_left_next = bytes_dec;
        has_write       = 1'b1;
        if (done) begin
          phase_next = PH_ADDR_LO;
        end else begin
          cur_address_next = cur_address + sfwp_pkg::ADDR_STEP;
          phase_next       = PH_DATA_LO;
        end
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase

    // The sync run is checked after the byte has gone through the phase logic.
    run_inc       = (byte_in == sfwp_pkg::SYNC_BYTE) ? sync_run + 3'd1 : '0;
    sync_run_next = run_inc;
    if (run_inc == RUN_LEN) begin
      phase_next    = PH_ADDR_LO;
      sync_run_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_WAIT;
      sync_run <= '0;
    end else if (fire) begin
      phase    <= phase_next;
      sync_run <= sync_run_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cur_address <= cur_address_next;
      bytes_left  <= bytes_left_next;
      low_byte    <= low_byte_next;
    end
  end

endmodule

/* sv/sfwp_out_fifo.sv */
// Two-entry output queue that decouples the parser from the result receiver.
// Depends on sfwp_pkg for the write type.
module sfwp_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sfwp_pkg::write_t  push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_stall,
  output sfwp_pkg::write_t  out_data
);

  sfwp_pkg::write_t entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign space     = (count != 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

/* sv/sync_framed_write_stream_parser_core.sv */
// Top level of the framed write stream parser: input register, parse state
// machine and output queue. Depends on sfwp_pkg, sfwp_parser, sfwp_out_fifo.
//
// Usage: bytes of the stream arrive on byte_in with in_valid; a byte is taken
// at a clock edge where in_valid is high and in_stall is low. After
// SYNC_RUN_LENGTH consecutive 0x55 bytes the block reads records (address,
// count, data words, all little-endian) and emits one write word per data
// word on write_address, write_data and frame_end, qualified by out_valid
// and held while out_stall is high.
// Throughput is one byte per cycle while in_stall is low. A byte is captured
// in the input register and handled by the parse logic; its write, if any,
// enters the output queue at the edge where the byte leaves the input
// register, and out_valid comes from the queue's count register. The parser
// state update is combinational logic between registers, so the only limit
// on rate is room in the two-entry output queue.
// When the receiver stalls, the queue fills; once it is full, a byte that
// completes a data word waits in the input register and in_stall rises.
// Bytes that make no write still pass through while the queue is full.
// Reset (rst, synchronous) empties the input register and the queue and puts
// the parser back to waiting for sync with a zero sync run. Address, count
// and held low byte are not reset; they are always written before use.
module sync_framed_write_stream_parser_core #(
  parameter int SYNC_RUN_LENGTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sfwp_pkg::BYTE_W-1:0]  byte_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sfwp_pkg::ADDR_W-1:0]  write_address,
  output logic [sfwp_pkg::DATA_W-1:0]  write_data,
  output logic                         frame_end
);

  // Input register holding the byte under work.
  logic                        s1_valid;
  logic [sfwp_pkg::BYTE_W-1:0] s1_byte;
  logic                        s1_fire;
  logic                        in_accept;

  logic             has_write;
  logic             fifo_space;
  sfwp_pkg::write_t parsed;
  sfwp_pkg::write_t queued;

  // A byte leaves the input register unless it makes a write and the queue
  // is full. Everything here comes from registers, so in_stall does not
  // depend on out_stall combinationally.
  assign s1_fire   = s1_valid && (!has_write || fifo_space);
  assign in_stall  = s1_valid && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= byte_in;
    end
  end

  sfwp_parser #(
    .SYNC_RUN_LENGTH(SYNC_RUN_LENGTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (s1_fire),
    .byte_in   (s1_byte),
    .has_write (has_write),
    .write_out (parsed)
  );

  sfwp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_fire && has_write),
    .push_data (parsed),
    .space     (fifo_space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (queued)
  );

  assign write_address = queued.address;
  assign write_data    = queued.data;
  assign frame_end     = queued.frame_end;

`ifndef SYNTHESIS
  // A byte held back in the input register keeps its value.
  a_held_byte: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_byte))
    else $error("held input byte changed or was lost");

  // The queue can only be full while it offers a result.
  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    !fifo_space |-> out_valid)
    else $error("output queue full without a valid result");

  // A frame end is only flagged on the end-of-frame address.
  a_frame_end_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> write_address == sfwp_pkg::END_ADDRESS)
    else $error("frame end on a write not at the end-of-frame address");

  // Input is stalled only when a write is blocked by a full queue.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> has_write && !fifo_space)
    else $error("input stalled without a blocked write");
`endif

endmodule
